FILE: design/velocity_pi_duty_controller_top_macros.svh
// Assertion helpers shared by the controller RTL.
`ifndef VELOCITY_PI_DUTY_CONTROLLER_TOP_MACROS_SVH
`define VELOCITY_PI_DUTY_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VPDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define VPDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vpdc_pkg.sv
package vpdc_pkg;

	// Width of the speed, duty and register data fields.
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Constant division by reciprocal multiplication.
	localparam int unsigned DEN_W       = 17;
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned RECIP_SHIFT = 33;
	localparam int unsigned DIV_T_W     = 33;
	localparam int unsigned SCALED_W    = 33;

	// Register reset values.
	localparam logic [FIELD_W-1:0] KP_RESET     = 16'd10000;
	localparam logic [FIELD_W-1:0] KI_RESET     = 16'd125;
	localparam logic [FIELD_W-1:0] LOWER_RESET  = 16'd500;
	localparam logic [FIELD_W-1:0] UPPER_RESET  = 16'd9000;
	localparam logic [FIELD_W-1:0] DEAD_RESET   = 16'd50;
	localparam logic [FIELD_W-1:0] FINE_RESET   = 16'd20;
	localparam logic [FIELD_W-1:0] COARSE_RESET = 16'd4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONTROL_MODE   = 3'd0,
		REG_KP_MILLI       = 3'd1,
		REG_KI_GAIN        = 3'd2,
		REG_LOWER_LIMIT    = 3'd3,
		REG_UPPER_LIMIT    = 3'd4,
		REG_INCR_DEAD_BAND = 3'd5,
		REG_FINE_BAND      = 3'd6,
		REG_COARSE_BAND    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_POS_PI = 2'd0,
		MODE_BAND_P = 2'd1,
		MODE_INC_PI = 2'd2,
		MODE_HOLD   = 2'd3
	} ctrl_mode_t;

	// Denominator of the unrounded duty.
	typedef enum logic [1:0] {
		DEN_1      = 2'd0,
		DEN_100    = 2'd1,
		DEN_1000   = 2'd2,
		DEN_100000 = 2'd3
	} den_t;

	// Shape of the duty expression chosen for one beat.
	typedef enum logic [2:0] {
		FORM_HOLD     = 3'd0,
		FORM_P_COARSE = 3'd1,
		FORM_P_FINE   = 3'd2,
		FORM_POS_PI   = 3'd3,
		FORM_INC_PI   = 3'd4
	} form_t;

	typedef struct packed {
		ctrl_mode_t         mode;
		logic [FIELD_W-1:0] kp_milli;
		logic [FIELD_W-1:0] ki_gain;
		logic [FIELD_W-1:0] lower_limit;
		logic [FIELD_W-1:0] upper_limit;
		logic [FIELD_W-1:0] incr_dead_band;
		logic [FIELD_W-1:0] fine_band;
		logic [FIELD_W-1:0] coarse_band;
	} cfg_t;

	function automatic logic [DEN_W-1:0] den_value(den_t d);
		logic [DEN_W-1:0] v;
		unique case (d)
			DEN_1:      v = 17'd1;
			DEN_100:    v = 17'd100;
			DEN_1000:   v = 17'd1000;
			DEN_100000: v = 17'd100000;
		endcase
		return v;
	endfunction

	// floor(2^33 / den); the unit-denominator path bypasses the multiplier.
	function automatic logic [RECIP_W-1:0] den_recip(den_t d);
		logic [RECIP_W-1:0] v;
		unique case (d)
			DEN_1:      v = '0;
			DEN_100:    v = 27'd85899345;
			DEN_1000:   v = 27'd8589934;
			DEN_100000: v = 27'd85899;
		endcase
		return v;
	endfunction

	// A 16-bit value times the denominator, as shifts and adds.
	function automatic logic [SCALED_W-1:0] scale_by_den(logic [FIELD_W-1:0] v, den_t d);
		logic [SCALED_W-1:0] x;
		logic [SCALED_W-1:0] r;
		x = SCALED_W'(v);
		unique case (d)
			DEN_1:      r = x;
			DEN_100:    r = (x << 6) + (x << 5) + (x << 2);
			DEN_1000:   r = (x << 10) - (x << 4) - (x << 3);
			DEN_100000: r = (x << 16) + (x << 15) + (x << 10) + (x << 9) + (x << 7)
				+ (x << 5);
		endcase
		return r;
	endfunction

endpackage

FILE: design/vpdc_if.sv
// Speed sample channel.
interface vpdc_in_if import vpdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] speed_target;
	logic [FIELD_W-1:0] measured_speed;
	logic [FIELD_W-1:0] present_duty;

	modport source(output valid, output speed_target, output measured_speed,
		output present_duty, input ready);
	modport sink(input valid, input speed_target, input measured_speed,
		input present_duty, output ready);
endinterface

// Duty result channel.
interface vpdc_out_if import vpdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] duty;
	logic               at_limit;

	modport source(output valid, output duty, output at_limit, input ready);
	modport sink(input valid, input duty, input at_limit, output ready);
endinterface

// Register write channel.
interface vpdc_cfg_if import vpdc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/velocity_pi_duty_controller_top.sv
// Channel    Role    Payload
// cfg_wr     sink    index[2:0], data[15:0]
// item_in    sink    speed_target, measured_speed, present_duty
// item_out   source  duty, at_limit
//
// Sustained rate is one beat per cycle while item_out is not stalled; a result
// is offered once its beat has passed six register stages (input, products, sum,
// clamp, reciprocal multiply, output register after the remainder correction).
// Reset clears all stage valid bits, the error integral and the registers.
// Each stage holds while the next is full and stalled, so inputs are taken
// as long as the first stage is empty or moving.
`include "velocity_pi_duty_controller_top_macros.svh"

module velocity_pi_duty_controller_top import vpdc_pkg::*; #(
	parameter int unsigned INTEGRAL_WIDTH = 32,
	parameter int unsigned SPEED_WIDTH    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	vpdc_cfg_if.sink     cfg_wr,
	vpdc_in_if.sink      item_in,
	vpdc_out_if.source   item_out
);

	localparam int unsigned IW     = INTEGRAL_WIDTH;
	localparam int unsigned SW     = SPEED_WIDTH;
	localparam int unsigned EW     = SW + 1;
	localparam int unsigned CW     = (EW > FIELD_W) ? EW : FIELD_W;
	localparam int unsigned KPE_W  = EW + FIELD_W + 1;
	localparam int unsigned KII_W  = IW + FIELD_W + 1;
	localparam int unsigned TW_A   = (KII_W > KPE_W + 8) ? KII_W : KPE_W + 8;
	localparam int unsigned TW     = ((TW_A > 34) ? TW_A : 34) + 1;
	localparam bit          HUGE_ON = (KII_W > 63);
	localparam logic signed [TW-1:0] BIG_LIM     = TW'(1) << 62;
	localparam logic signed [TW-1:0] NEG_BIG_LIM = -BIG_LIM;

	cfg_t cfg;

	vpdc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	// Stage valid bits and ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || item_out.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign item_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_in.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: registered input beat.
	logic [FIELD_W-1:0] ref_s1, meas_s1, duty_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ref_s1  <= item_in.speed_target;
			meas_s1 <= item_in.measured_speed;
			duty_s1 <= item_in.present_duty;
		end
	end

	// Error, band tests and choice of duty expression.
	logic [SW-1:0]        ref_w, meas_w;
	logic signed [EW-1:0] e_c;
	logic [EW-1:0]        abs_e_c;
	logic                 past_coarse, past_fine, past_dead;
	form_t                form_c;
	logic signed [KPE_W-1:0] kpe_c;
	logic signed [KII_W-1:0] kii_c;
	logic signed [IW-1:0] error_sum_q;
	logic signed [IW-1:0] e_iw_c;
	logic                 fire_s2;

	assign ref_w   = SW'(ref_s1);
	assign meas_w  = SW'(meas_s1);
	assign e_c     = $signed({1'b0, ref_w}) - $signed({1'b0, meas_w});
	assign abs_e_c = e_c[EW-1] ? (~e_c + 1'b1) : e_c;
	assign past_coarse = CW'(abs_e_c) > CW'(cfg.coarse_band);
	assign past_fine   = CW'(abs_e_c) > CW'(cfg.fine_band);
	assign past_dead   = CW'(abs_e_c) > CW'(cfg.incr_dead_band);
	assign e_iw_c  = IW'(e_c);
	assign fire_s2 = v_s1 && rdy_s2;

	always_comb begin
		unique case (cfg.mode)
			MODE_POS_PI: form_c = FORM_POS_PI;
			MODE_BAND_P: begin
				if (past_coarse)    form_c = FORM_P_COARSE;
				else if (past_fine) form_c = FORM_P_FINE;
				else                form_c = FORM_HOLD;
			end
			MODE_INC_PI: form_c = past_dead ? FORM_INC_PI : FORM_HOLD;
			MODE_HOLD:   form_c = FORM_HOLD;
		endcase
	end

	assign kpe_c = $signed({1'b0, cfg.kp_milli}) * e_c;
	assign kii_c = $signed({1'b0, cfg.ki_gain}) * error_sum_q;

	// Error integral: read before the beat, moved only when the block adjusts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
		end else if (fire_s2 && (form_c != FORM_HOLD)) begin
			error_sum_q <= error_sum_q + e_iw_c;
		end
	end

	// Stage 2: products.
	form_t                   form_s2;
	logic [FIELD_W-1:0]      duty_s2;
	logic signed [EW-1:0]    e_s2;
	logic signed [KPE_W-1:0] kpe_s2;
	logic signed [KII_W-1:0] kii_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			form_s2 <= form_c;
			duty_s2 <= duty_s1;
			e_s2    <= e_c;
			kpe_s2  <= kpe_c;
			kii_s2  <= kii_c;
		end
	end

	// Numerator terms over the common denominator.
	logic signed [TW-1:0] duty_x, e_x, kpe_x, big_c, small_c;
	logic signed [TW-1:0] duty100, duty1e5, kpe100;
	den_t                 den_c;
	logic                 huge_pos_c, huge_neg_c;

	assign duty_x  = TW'(duty_s2);
	assign e_x     = TW'(e_s2);
	assign kpe_x   = TW'(kpe_s2);
	assign duty100 = (duty_x <<< 6) + (duty_x <<< 5) + (duty_x <<< 2);
	assign duty1e5 = (duty_x <<< 16) + (duty_x <<< 15) + (duty_x <<< 10) + (duty_x <<< 9)
		+ (duty_x <<< 7) + (duty_x <<< 5);
	assign kpe100  = (kpe_x <<< 6) + (kpe_x <<< 5) + (kpe_x <<< 2);

	always_comb begin
		unique case (form_s2)
			FORM_HOLD: begin
				den_c = DEN_1;
				big_c = '0;
				small_c = duty_x;
			end
			FORM_P_COARSE: begin
				den_c = DEN_100;
				big_c = '0;
				small_c = duty100 + (e_x <<< 1);
			end
			FORM_P_FINE: begin
				den_c = DEN_100;
				big_c = '0;
				small_c = duty100 + e_x;
			end
			FORM_POS_PI: begin
				den_c = DEN_1000;
				big_c = TW'(kii_s2);
				small_c = kpe_x;
			end
			FORM_INC_PI: begin
				den_c = DEN_100000;
				big_c = TW'(kii_s2);
				small_c = duty1e5 + kpe100;
			end
			default: begin
				den_c = DEN_1;
				big_c = '0;
				small_c = duty_x;
			end
		endcase
	end

	// An integral term past 2^62 settles the result by its sign alone.
	assign huge_pos_c = HUGE_ON && (big_c > BIG_LIM);
	assign huge_neg_c = HUGE_ON && (big_c < NEG_BIG_LIM);

	// Stage 3: terms and scaled limits.
	logic signed [TW-1:0] big_s3, small_s3;
	den_t                 den_s3;
	logic [SCALED_W-1:0]  up_sc_s3, lo_sc_s3;
	logic                 huge_pos_s3, huge_neg_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			big_s3      <= big_c;
			small_s3    <= small_c;
			den_s3      <= den_c;
			up_sc_s3    <= scale_by_den(cfg.upper_limit, den_c);
			lo_sc_s3    <= scale_by_den(cfg.lower_limit, den_c);
			huge_pos_s3 <= huge_pos_c;
			huge_neg_s3 <= huge_neg_c;
		end
	end

	// Exact numerator against the scaled limits; upper test wins.
	logic signed [TW-1:0] total_c, up_x, lo_x;
	logic                 hi_c, lo_c;

	assign total_c = big_s3 + small_s3;
	assign up_x    = TW'(up_sc_s3);
	assign lo_x    = TW'(lo_sc_s3);
	assign hi_c    = huge_pos_s3 || (!huge_neg_s3 && (total_c >= up_x));
	assign lo_c    = !hi_c && (huge_neg_s3 || (total_c <= lo_x));

	// Stage 4: clamp decision and in-range numerator.
	logic               hi_s4, lo_s4;
	logic [DIV_T_W-1:0] t_s4;
	den_t               den_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			hi_s4  <= hi_c;
			lo_s4  <= lo_c;
			t_s4   <= total_c[DIV_T_W-1:0];
			den_s4 <= den_s3;
		end
	end

	// Quotient estimate, one below or exact.
	logic [DIV_T_W+RECIP_W-1:0] prod_c;
	logic [FIELD_W-1:0]         q0_c;

	assign prod_c = t_s4 * den_recip(den_s4);
	assign q0_c   = (den_s4 == DEN_1) ? t_s4[FIELD_W-1:0] : prod_c[RECIP_SHIFT +: FIELD_W];

	// Stage 5: estimate.
	logic               hi_s5, lo_s5;
	logic [DIV_T_W-1:0] t_s5;
	den_t               den_s5;
	logic [FIELD_W-1:0] q0_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			hi_s5  <= hi_s4;
			lo_s5  <= lo_s4;
			t_s5   <= t_s4;
			den_s5 <= den_s4;
			q0_s5  <= q0_c;
		end
	end

	// Remainder correction and final selection.
	logic [SCALED_W-1:0] qd_c;
	logic [DIV_T_W-1:0]  rem_c;
	logic [FIELD_W-1:0]  q_c, duty_c;

	assign qd_c  = scale_by_den(q0_s5, den_s5);
	assign rem_c = t_s5 - qd_c;
	assign q_c   = q0_s5 + FIELD_W'(rem_c >= DIV_T_W'(den_value(den_s5)));

	always_comb begin
		priority if (hi_s5) duty_c = cfg.upper_limit;
		else if (lo_s5)     duty_c = cfg.lower_limit;
		else                duty_c = q_c;
	end

	// Stage 6: output register.
	logic [FIELD_W-1:0] duty_s6;
	logic               lim_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			duty_s6 <= duty_c;
			lim_s6  <= hi_s5 || lo_s5;
		end
	end

	assign item_out.valid    = v_s6;
	assign item_out.duty     = duty_s6;
	assign item_out.at_limit = lim_s6;

	// Checks on the integral and the divider.
	`VPDC_ASSERT_NXT(a_sum_hold, clk, arst_n, fire_s2 && (form_c == FORM_HOLD), $stable(error_sum_q), "integral moved on a hold beat")
	`VPDC_ASSERT_NXT(a_sum_step, clk, arst_n, fire_s2 && (form_c != FORM_HOLD), error_sum_q == ($past(error_sum_q) + $past(e_iw_c)), "integral step differs from the error")
	`VPDC_ASSERT_IMP(a_rem_range, clk, arst_n, v_s5 && !hi_s5 && !lo_s5, rem_c < {den_value(den_s5), 1'b0}, "quotient estimate off by more than one")
	`VPDC_ASSERT_IMP(a_clamp_excl, clk, arst_n, v_s5, !(hi_s5 && lo_s5), "both clamp flags set")

endmodule

FILE: design/vpdc_cfg_regs.sv
module vpdc_cfg_regs import vpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vpdc_cfg_if.sink    cfg_wr,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_wr.ready = 1'b1;
	assign cfg        = cfg_q;

	// Register file with decoded write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_POS_PI;
			cfg_q.kp_milli       <= KP_RESET;
			cfg_q.ki_gain        <= KI_RESET;
			cfg_q.lower_limit    <= LOWER_RESET;
			cfg_q.upper_limit    <= UPPER_RESET;
			cfg_q.incr_dead_band <= DEAD_RESET;
			cfg_q.fine_band      <= FINE_RESET;
			cfg_q.coarse_band    <= COARSE_RESET;
		end else if (cfg_wr.valid) begin
			unique case (reg_idx_t'(cfg_wr.index))
				REG_CONTROL_MODE:   cfg_q.mode           <= ctrl_mode_t'(cfg_wr.data[1:0]);
				REG_KP_MILLI:       cfg_q.kp_milli       <= cfg_wr.data;
				REG_KI_GAIN:        cfg_q.ki_gain        <= cfg_wr.data;
				REG_LOWER_LIMIT:    cfg_q.lower_limit    <= cfg_wr.data;
				REG_UPPER_LIMIT:    cfg_q.upper_limit    <= cfg_wr.data;
				REG_INCR_DEAD_BAND: cfg_q.incr_dead_band <= cfg_wr.data;
				REG_FINE_BAND:      cfg_q.fine_band      <= cfg_wr.data;
				REG_COARSE_BAND:    cfg_q.coarse_band    <= cfg_wr.data;
			endcase
		end
	end

endmodule
